FILE: hw/rtl/wsfs_pkg.sv
// wsfs_pkg: shared types and constants of the websocket frame segmenter
// no dependencies; imported by every module of the block

package wsfs_pkg;

  localparam int unsigned FS_W = 24;

  localparam logic [FS_W-1:0] FRAME_SIZE_RESET = 24'd2048;

  localparam logic [7:0] LEAD_FIN_TEXT = 8'h81;
  localparam logic [7:0] LEAD_TEXT     = 8'h01;
  localparam logic [7:0] LEAD_FIN_CONT = 8'h80;
  localparam logic [7:0] LEAD_CONT     = 8'h00;
  localparam logic [7:0] LEN_16_CODE   = 8'd126;
  localparam logic [7:0] LEN_64_CODE   = 8'd127;

  localparam logic [FS_W-1:0] LEN_7_LIMIT  = 24'd126;
  localparam logic [FS_W-1:0] LEN_16_MAX   = 24'd65535;

  typedef enum logic [1:0] {
    FORM_7  = 2'd0,
    FORM_16 = 2'd1,
    FORM_64 = 2'd2
  } len_form_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            hdr;
    logic [7:0]      lead;
    len_form_t       form;
    logic [FS_W-1:0] flen;
    logic            fend;
  } desc_t;

endpackage

FILE: hw/rtl/wsfs_front.sv
// wsfs_front: accepts message bytes, tracks message and frame counters and
// classifies each byte into a frame descriptor; uses wsfs_pkg

module wsfs_front import wsfs_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [FS_W-1:0] cfg_wr_data,
  input  logic            acc,
  input  logic [7:0]      data_byte,
  input  logic            start_of_message,
  input  logic [31:0]     message_length,
  input  logic            binary,
  output logic            push,
  output desc_t           push_desc
);

  localparam int unsigned LW = (LENGTH_BITS > FS_W) ? LENGTH_BITS : FS_W;

  logic [FS_W-1:0]        frame_size_r, frame_size_nxt;
  logic [LENGTH_BITS-1:0] msg_rem_r, msg_rem_nxt;
  logic [FS_W-1:0]        frm_rem_r, frm_rem_nxt;
  logic                   first_r, first_nxt;
  logic                   bin_r, bin_nxt;

  logic [LENGTH_BITS-1:0] mr;
  logic [FS_W-1:0]        fr, fs, flen, fr_use;
  logic                   first, bin, need_hdr, last, active;
  logic [LW-1:0]          mr_ext, fs_ext;

  always_comb begin
    mr       = start_of_message ? LENGTH_BITS'(message_length) : msg_rem_r;
    fr       = start_of_message ? '0 : frm_rem_r;
    first    = start_of_message | first_r;
    bin      = start_of_message ? binary : bin_r;
    active   = (mr != '0);
    need_hdr = (fr == '0);
    fs       = (frame_size_r == '0) ? FS_W'(1) : frame_size_r;
    mr_ext   = LW'(mr);
    fs_ext   = LW'(fs);
    flen     = (mr_ext < fs_ext) ? mr_ext[FS_W-1:0] : fs;
    last     = (mr_ext <= fs_ext);
    fr_use   = need_hdr ? flen : fr;

    push_desc.data = data_byte;
    push_desc.hdr  = need_hdr;
    push_desc.flen = flen;
    push_desc.fend = (fr_use == FS_W'(1));
    if (first) begin
      push_desc.lead = (last ? LEAD_FIN_TEXT : LEAD_TEXT) + {7'd0, bin};
    end else begin
      push_desc.lead = last ? LEAD_FIN_CONT : LEAD_CONT;
    end
    if (flen < LEN_7_LIMIT) begin
      push_desc.form = FORM_7;
    end else if (flen <= LEN_16_MAX) begin
      push_desc.form = FORM_16;
    end else begin
      push_desc.form = FORM_64;
    end
    push = acc & active;

    frame_size_nxt = cfg_wr_en ? cfg_wr_data : frame_size_r;
    msg_rem_nxt    = msg_rem_r;
    frm_rem_nxt    = frm_rem_r;
    first_nxt      = first_r;
    bin_nxt        = bin_r;
    if (acc) begin
      bin_nxt   = bin;
      first_nxt = first;
      if (active) begin
        msg_rem_nxt = mr - LENGTH_BITS'(1);
        frm_rem_nxt = fr_use - FS_W'(1);
        if (need_hdr) begin
          first_nxt = 1'b0;
        end
      end else begin
        msg_rem_nxt = mr;
        frm_rem_nxt = fr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RESET;
      msg_rem_r    <= '0;
      frm_rem_r    <= '0;
      first_r      <= 1'b0;
      bin_r        <= 1'b0;
    end else begin
      frame_size_r <= frame_size_nxt;
      msg_rem_r    <= msg_rem_nxt;
      frm_rem_r    <= frm_rem_nxt;
      first_r      <= first_nxt;
      bin_r        <= bin_nxt;
    end
  end

  // a frame never holds more bytes than the message still owes
  a_frame_within_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (msg_rem_r == '0) |-> (frm_rem_r == '0))
    else $error("frame counter open with no message");

  a_hdr_flen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_desc.hdr) |-> (push_desc.flen != '0))
    else $error("header with empty frame");

endmodule

FILE: hw/rtl/wsfs_queue.sv
// wsfs_queue: short descriptor queue between front and back
// uses wsfs_pkg for the descriptor type

module wsfs_queue import wsfs_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  localparam int unsigned AW = $clog2(DEPTH);

  desc_t         entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full       = (count_r == (AW+1)'(DEPTH));
    head_valid = (count_r != '0);
    head_desc  = entries_r[rd_ptr_r];
    do_push    = push & ~full;
    do_pop     = pop & head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

FILE: hw/rtl/wsfs_back.sv
// wsfs_back: expands descriptors into header bytes and the payload byte,
// one wire byte per cycle into the output register while out_tready allows; uses wsfs_pkg

module wsfs_back import wsfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  desc_t      head_desc,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  logic [3:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       hdr_r, hdr_nxt;
  logic       fend_r, fend_nxt;
  logic       lor_r, lor_nxt;
  logic [3:0] hn;
  logic [7:0] hbyte;
  logic       emit, at_payload;

  always_comb begin
    hn = 4'd0;
    if (head_desc.hdr) begin
      unique case (head_desc.form)
        FORM_7:  hn = 4'd2;
        FORM_16: hn = 4'd4;
        FORM_64: hn = 4'd10;
        default: hn = 4'd2;
      endcase
    end

    hbyte = 8'd0;
    if (step_r == 4'd0) begin
      hbyte = head_desc.lead;
    end else begin
      unique case (head_desc.form)
        FORM_7: begin
          hbyte = {1'b0, head_desc.flen[6:0]};
        end
        FORM_16: begin
          unique case (step_r)
            4'd1:    hbyte = LEN_16_CODE;
            4'd2:    hbyte = head_desc.flen[15:8];
            default: hbyte = head_desc.flen[7:0];
          endcase
        end
        FORM_64: begin
          unique case (step_r)
            4'd1:    hbyte = LEN_64_CODE;
            4'd7:    hbyte = head_desc.flen[23:16];
            4'd8:    hbyte = head_desc.flen[15:8];
            4'd9:    hbyte = head_desc.flen[7:0];
            default: hbyte = 8'd0;
          endcase
        end
        default: hbyte = 8'd0;
      endcase
    end

    emit       = head_valid & (~ov_r | out_tready);
    at_payload = (step_r == hn);
    pop        = emit & at_payload;

    step_nxt = step_r;
    ov_nxt   = ov_r & ~out_tready;
    byte_nxt = byte_r;
    hdr_nxt  = hdr_r;
    fend_nxt = fend_r;
    lor_nxt  = lor_r;
    if (emit) begin
      ov_nxt = 1'b1;
      if (at_payload) begin
        step_nxt = 4'd0;
        byte_nxt = head_desc.data;
        hdr_nxt  = 1'b0;
        fend_nxt = head_desc.fend;
        lor_nxt  = 1'b1;
      end else begin
        step_nxt = step_r + 4'd1;
        byte_nxt = hbyte;
        hdr_nxt  = 1'b1;
        fend_nxt = 1'b0;
        lor_nxt  = 1'b0;
      end
    end

    out_tvalid = ov_r;
    out_tdata  = byte_r;
    out_tlast  = fend_r;
    out_tuser  = {lor_r, hdr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    hdr_r  <= hdr_nxt;
    fend_r <= fend_nxt;
    lor_r  <= lor_nxt;
  end

  // header bytes never close a frame or a run
  a_hdr_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (!out_tlast && !out_tuser[1]))
    else $error("header byte carries end flags");

  // a header in progress keeps its descriptor at the queue head
  a_step_holds_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 4'd0) |-> head_valid)
    else $error("header walk without descriptor");

endmodule

FILE: hw/rtl/websocket_frame_segmenter_core.sv
// websocket_frame_segmenter_core: top level of the frame segmenter
// instantiates wsfs_front, wsfs_queue and wsfs_back; uses wsfs_pkg
//
//  channel  dir  handshake          payload
//  in_      in   tvalid / tready    tdata {message_length, data_byte}, tuser {binary, start}
//  out_     out  tvalid / tready    tdata out_byte, tuser {last_of_run, is_header}, tlast
//  cfg_     in   wr_en              wr_data frame_size
//
// a payload byte inside a frame goes out as one wire byte; a byte that opens a
// frame goes out as 3, 5 or 11 wire bytes, as the back end walks the header one
// byte per cycle while out_tready allows. input accepts one byte per cycle while
// the descriptor queue has room. reset is synchronous, no clearing pass. both
// sides stall independently through the queue and the output register.

module websocket_frame_segmenter_core import wsfs_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,   // frame_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // data_byte [7:0], message_length [39:8]
  input  logic [1:0]  in_tuser,      // start_of_message [0], binary [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // out_byte [7:0]
  output logic        out_tlast,     // frame_end
  output logic [1:0]  out_tuser      // is_header [0], last_of_run [1]
);

  logic  acc, push, full, pop, head_valid;
  desc_t push_desc, head_desc;

  assign in_tready = ~full;
  assign acc       = in_tvalid & ~full;

  wsfs_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .acc              (acc),
    .data_byte        (in_tdata[7:0]),
    .start_of_message (in_tuser[0]),
    .message_length   (in_tdata[39:8]),
    .binary           (in_tuser[1]),
    .push             (push),
    .push_desc        (push_desc)
  );

  wsfs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  wsfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_tvalid && in_tready))
    else $error("descriptor pushed without input transaction");

endmodule
